// File: rtl/core/r2e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2e_pkg
// Shared constants for the rotation matrix to Euler angle converter.
// ----------------------------------------------------------------------------
package r2e_pkg;

    localparam int DEF_ENTRY_WIDTH  = 16;
    localparam int DEF_CORDIC_STEPS = 16;

    localparam int OUT_W = 22;
    localparam logic signed [OUT_W-1:0] OUT_LIMIT = 22'sd1474560;

    // pi/2 in Q.30
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    // round(180/pi * 2^24), split in two 15-bit halves for the multiplier
    localparam logic [29:0] DEG_K = 30'd961263669;

    // atan(2^-i) in Q.30
    localparam logic [29:0] ATAN_TAB [32] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
        30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
        30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
    };

    // configuration register indexes
    localparam logic CFG_DEGREE_MODE = 1'b0;
    localparam logic CFG_GIMBAL_TOL  = 1'b1;

    // gimbal case codes
    localparam logic [1:0] GC_REGULAR    = 2'd0;
    localparam logic [1:0] GC_NEAR_MINUS = 2'd1;
    localparam logic [1:0] GC_NEAR_PLUS  = 2'd2;

endpackage

// File: rtl/core/rotation_matrix_to_euler_angles_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles_top
// ZYX Euler angles (phi, theta, psi) from a rotation matrix, pipelined CORDIC.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  tdata: r00 r01 r02 r10 r20 r21 r22
//  m_       out  m_tvalid/m_tready  tdata: phi theta psi, tuser: gimbal_case
//  cfg_     in   cfg_valid/ready    cfg_index, cfg_data
//
//  One word per cycle in and out unless held. Stages: input register,
//  square, radicand, ENTRY_WIDTH-1 square-root digit stages, CORDIC
//  pre-rotation, CORDIC_STEPS rotation stages (capped at the arctangent
//  table size), angle select, degree-scale multiply, output register.
//  Reset clears the valid bits and the configuration registers.
//  When the output word is held by m_tready low, the whole pipe freezes;
//  s_tready drops in the same cycle, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_angles_top #(
    parameter int ENTRY_WIDTH  = r2e_pkg::DEF_ENTRY_WIDTH,
    parameter int CORDIC_STEPS = r2e_pkg::DEF_CORDIC_STEPS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // r00, r01, r02, r10, r20, r21, r22 from bit 0 up, zero padded
    input  logic [((7*ENTRY_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // angle_phi, angle_theta, angle_psi from bit 0 up, zero padded
    output logic [71:0] m_tdata,
    // gimbal_case
    output logic [1:0] m_tuser,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_index,
    input  logic [9:0] cfg_data
);
    import r2e_pkg::*;

    localparam int EW   = ENTRY_WIDTH;
    localparam int IN_W = ((7*EW+7)/8)*8;
    localparam int OW   = EW + 1;             // operand width after negation
    localparam int SH   = 46 - EW;            // CORDIC input scale
    localparam int CW   = 51;                 // CORDIC x/y width
    localparam int ZW   = 34;                 // Q.30 angle width
    localparam int SQ   = EW - 1;             // square-root digits
    localparam int NW2  = 2 * SQ;             // radicand width
    localparam int RW   = EW + 1;             // remainder width
    localparam int ST   = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int PPW  = ZW + 16;
    localparam int PW   = 66;

    localparam logic signed [EW+1:0] ONE = (EW+2)'(1) <<< (EW - 2);
    localparam logic [NW2-1:0] ONE_SQ = NW2'(1) << (2*EW - 4);
    localparam logic signed [ZW-1:0] HPZ = ZW'(HALF_PI_Q30);
    localparam logic [14:0] K_LO = DEG_K[14:0];
    localparam logic [14:0] K_HI = DEG_K[29:15];

    typedef struct packed {
        logic [1:0]             gc;
        logic signed [OW-1:0]   py;
        logic signed [OW-1:0]   px;
        logic signed [OW-1:0]   qy;
        logic signed [OW-1:0]   qx;
        logic signed [OW-1:0]   ty;
    } side_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 nz;
    } cch_t;

    function automatic cch_t cprep(input logic signed [OW-1:0] y,
                                   input logic signed [OW-1:0] x);
        cch_t c;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        xs = CW'(x) <<< SH;
        ys = CW'(y) <<< SH;
        c.nz = (x != '0) || (y != '0);
        if (xs < 0) begin
            if (ys >= 0) begin
                c.x = ys;
                c.y = -xs;
                c.z = HPZ;
            end else begin
                c.x = -ys;
                c.y = xs;
                c.z = -HPZ;
            end
        end else begin
            c.x = xs;
            c.y = ys;
            c.z = '0;
        end
        return c;
    endfunction

    function automatic cch_t cstep(input cch_t c, input logic [4:0] sh);
        cch_t n;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [ZW-1:0] a;
        xs = c.x >>> sh;
        ys = c.y >>> sh;
        a  = ZW'(ATAN_TAB[sh]);
        n.nz = c.nz;
        if (c.y >= 0) begin
            n.x = c.x + ys;
            n.y = c.y - xs;
            n.z = c.z + a;
        end else begin
            n.x = c.x - ys;
            n.y = c.y + xs;
            n.z = c.z - a;
        end
        return n;
    endfunction

    function automatic logic [OUT_W-1:0] sat(input logic signed [PW-1:0] v);
        logic [OUT_W-1:0] r;
        if (v > PW'(OUT_LIMIT)) r = OUT_LIMIT;
        else if (v < -PW'(OUT_LIMIT)) r = -OUT_LIMIT;
        else r = v[OUT_W-1:0];
        return r;
    endfunction

    // configuration
    logic       degree_mode_reg;
    logic [9:0] gimbal_tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_mode_reg <= 1'b0;
            gimbal_tol_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DEGREE_MODE: degree_mode_reg <= cfg_data[0];
                CFG_GIMBAL_TOL:  gimbal_tol_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // global pipe enable: freeze only when the output word is stuck
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage 1: input register
    logic            v1_reg;
    logic [IN_W-1:0] in_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en)  v1_reg <= s_tvalid;
        if (en) in_reg <= s_tdata;
    end

    // stage 2: singular test, operand select, r20 squared
    logic signed [EW-1:0] r00, r01, r02, r10, r20, r21, r22;
    assign r00 = in_reg[0*EW +: EW];
    assign r01 = in_reg[1*EW +: EW];
    assign r02 = in_reg[2*EW +: EW];
    assign r10 = in_reg[3*EW +: EW];
    assign r20 = in_reg[4*EW +: EW];
    assign r21 = in_reg[5*EW +: EW];
    assign r22 = in_reg[6*EW +: EW];

    logic signed [EW+1:0] dm, dp, adm, adp, ar20;
    side_t                side_next;

    always_comb begin
        dm   = (EW+2)'(r20) + ONE;
        dp   = (EW+2)'(r20) - ONE;
        adm  = dm[EW+1] ? -dm : dm;
        adp  = dp[EW+1] ? -dp : dp;
        ar20 = r20[EW-1] ? -(EW+2)'(r20) : (EW+2)'(r20);
        side_next.qy = OW'(r10);
        side_next.qx = OW'(r00);
        side_next.ty = OW'(r20);
        // near minus one is tested first
        priority if (adm <= (EW+2)'(gimbal_tol_reg)) begin
            side_next.gc = GC_NEAR_MINUS;
            side_next.py = OW'(r01);
            side_next.px = OW'(r02);
        end else if (adp <= (EW+2)'(gimbal_tol_reg)) begin
            side_next.gc = GC_NEAR_PLUS;
            side_next.py = -OW'(r01);
            side_next.px = -OW'(r02);
        end else begin
            side_next.gc = GC_REGULAR;
            side_next.py = OW'(r21);
            side_next.px = OW'(r22);
        end
    end

    logic                v2_reg;
    side_t               s2_side_reg;
    logic [2*EW-1:0]     sq_reg;
    logic                lt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en)  v2_reg <= v1_reg;
        if (en) begin
            s2_side_reg <= side_next;
            sq_reg      <= (2*EW)'(r20 * r20);
            lt_reg      <= ar20 < ONE;
        end
    end

    // square-root digit pipeline, c = floor(sqrt(one^2 - r20^2))
    logic            sv_reg   [0:SQ];
    side_t           ss_reg   [0:SQ];
    logic [NW2-1:0]  rad_reg  [0:SQ];
    logic [RW-1:0]   rem_reg  [0:SQ];
    logic [SQ-1:0]   root_reg [0:SQ];

    always_ff @(posedge aclk) begin
        if (!aresetn) sv_reg[0] <= 1'b0;
        else if (en)  sv_reg[0] <= v2_reg;
        if (en) begin
            ss_reg[0]   <= s2_side_reg;
            rad_reg[0]  <= lt_reg ? ONE_SQ - NW2'(sq_reg) : '0;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k <= SQ; k++) begin : g_sqrt
        logic [RW+1:0] remt, trial;
        logic          ge;
        assign remt  = {rem_reg[k-1], rad_reg[k-1][NW2-1 -: 2]};
        assign trial = (RW+2)'({root_reg[k-1], 2'b01});
        assign ge    = remt >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) sv_reg[k] <= 1'b0;
            else if (en)  sv_reg[k] <= sv_reg[k-1];
            if (en) begin
                ss_reg[k]   <= ss_reg[k-1];
                rad_reg[k]  <= rad_reg[k-1] << 2;
                rem_reg[k]  <= ge ? RW'(remt - trial) : RW'(remt);
                root_reg[k] <= {root_reg[k-1][SQ-2:0], ge};
            end
        end
    end

    // CORDIC: lane 0 phi, lane 1 theta, lane 2 psi
    logic            cv_reg [0:ST];
    logic [1:0]      cg_reg [0:ST];
    cch_t [2:0]      cs_reg [0:ST];

    always_ff @(posedge aclk) begin
        if (!aresetn) cv_reg[0] <= 1'b0;
        else if (en)  cv_reg[0] <= sv_reg[SQ];
        if (en) begin
            cg_reg[0]    <= ss_reg[SQ].gc;
            cs_reg[0][0] <= cprep(ss_reg[SQ].py, ss_reg[SQ].px);
            cs_reg[0][1] <= cprep(ss_reg[SQ].ty, OW'({1'b0, root_reg[SQ]}));
            cs_reg[0][2] <= cprep(ss_reg[SQ].qy, ss_reg[SQ].qx);
        end
    end

    for (genvar i = 0; i < ST; i++) begin : g_cordic
        always_ff @(posedge aclk) begin
            if (!aresetn) cv_reg[i+1] <= 1'b0;
            else if (en)  cv_reg[i+1] <= cv_reg[i];
            if (en) begin
                cg_reg[i+1] <= cg_reg[i];
                for (int l = 0; l < 3; l++) begin
                    cs_reg[i+1][l] <= cstep(cs_reg[i][l], 5'(i));
                end
            end
        end
    end

    // angle select for the singular cases
    logic                 vf_reg;
    logic [1:0]           gf_reg;
    logic signed [ZW-1:0] zf_reg [3];
    logic signed [ZW-1:0] zphi, zth, zpsi;

    always_comb begin
        zphi = cs_reg[ST][0].nz ? cs_reg[ST][0].z : '0;
        zpsi = (cs_reg[ST][2].nz && cg_reg[ST] == GC_REGULAR) ? cs_reg[ST][2].z : '0;
        unique case (cg_reg[ST])
            GC_NEAR_MINUS: zth = HPZ;
            GC_NEAR_PLUS:  zth = -HPZ;
            default:       zth = cs_reg[ST][1].nz ? -cs_reg[ST][1].z : '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vf_reg <= 1'b0;
        else if (en)  vf_reg <= cv_reg[ST];
        if (en) begin
            gf_reg    <= cg_reg[ST];
            zf_reg[0] <= zphi;
            zf_reg[1] <= zth;
            zf_reg[2] <= zpsi;
        end
    end

    // degree scale, partial products
    logic                  vm_reg;
    logic [1:0]            gm_reg;
    logic signed [ZW-1:0]  zm_reg  [3];
    logic signed [PPW-1:0] phi_reg [3];
    logic signed [PPW-1:0] plo_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) vm_reg <= 1'b0;
        else if (en)  vm_reg <= vf_reg;
        if (en) begin
            gm_reg <= gf_reg;
            for (int l = 0; l < 3; l++) begin
                zm_reg[l]  <= zf_reg[l];
                phi_reg[l] <= PPW'(zf_reg[l]) * PPW'(signed'({1'b0, K_HI}));
                plo_reg[l] <= PPW'(zf_reg[l]) * PPW'(signed'({1'b0, K_LO}));
            end
        end
    end

    // rounding, saturation, output register
    logic                 m_tvalid_reg;
    logic [1:0]           m_gc_reg;
    logic [OUT_W-1:0]     ang_reg  [3];
    logic [OUT_W-1:0]     ang_next [3];
    logic signed [PW-1:0] vdeg     [3];
    logic signed [PW-1:0] vrad     [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            vdeg[l] = ((PW'(phi_reg[l]) <<< 15) + PW'(plo_reg[l])
                       + (PW'(1) <<< 40)) >>> 41;
            vrad[l] = (PW'(zm_reg[l]) + (PW'(1) <<< 16)) >>> 17;
            ang_next[l] = sat(degree_mode_reg ? vdeg[l] : vrad[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid_reg <= 1'b0;
        else if (en)  m_tvalid_reg <= vm_reg;
        if (en) begin
            m_gc_reg <= gm_reg;
            for (int l = 0; l < 3; l++) ang_reg[l] <= ang_next[l];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, ang_reg[2], ang_reg[1], ang_reg[0]};
    assign m_tuser  = m_gc_reg;

    // checks
    a_psi_zero_singular: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != GC_REGULAR |-> m_tdata[65:44] == '0)
        else $error("psi not zero in singular case");

    a_gc_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("bad gimbal case code");

    a_theta_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[43:22]) <= OUT_LIMIT
                  && $signed(m_tdata[43:22]) >= -OUT_LIMIT)
        else $error("theta out of range");

endmodule
